// ----- hw/rtl/cqs_pkg.sv -----
// Shared types and codes for the circular queue with search.
package cqs_pkg;

   localparam int WORD_W   = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;

   typedef enum logic [KIND_W-1:0] {
      REQ_ENQ    = 2'd0,
      REQ_DEQ    = 2'd1,
      REQ_SEARCH = 2'd2,
      REQ_DUMP   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FOUND    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_DEQ,
      FSM_SCAN,
      FSM_DUMP
   } fsm_type;

endpackage

// ----- hw/rtl/cqs_store.sv -----
// Slot memory: one write port, one read port with registered data.
module cqs_store #(
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic signed [cqs_pkg::WORD_W-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic signed [cqs_pkg::WORD_W-1:0] rd_data
);

   logic signed [cqs_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic signed [cqs_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/circular_queue_with_search.sv -----
// Ring-buffer FIFO of signed words, search and dump; one slot read per cycle unless dump stalls.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   req     | in        | req_valid, req_ready, req_type, req_value
//   rsp     | out       | rsp_valid, rsp_ready, rsp_status, rsp_data, rsp_last
//
// Enqueue, full and empty answer from idle; dequeue goes via FSM_DEQ (registered slot read).
// Search does one compare per slot read from the memory port, until a hit or the last slot.
// Dump returns one beat per occupied slot; each beat waits on rsp_ready.
// Synchronous reset empties the queue; slot contents are not cleared.
// req_ready is high only when the sequencer is idle and the output register is free.
module circular_queue_with_search #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cqs_pkg::KIND_W-1:0]        req_type,
   input  logic signed [cqs_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cqs_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [cqs_pkg::WORD_W-1:0] rsp_data,
   output logic                              rsp_last
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   cqs_pkg::fsm_type state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [PTR_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [cqs_pkg::WORD_W-1:0] key_ff, key_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   cqs_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic signed [cqs_pkg::WORD_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               rsp_load;

   logic                               out_free;
   logic                               req_fire;
   logic                               is_empty;
   logic                               is_full;
   logic                               hit;
   logic                               cnt_last;
   cqs_pkg::req_kind_type              kind;

   logic                               wr_en;
   logic                               rd_en;
   logic [PTR_W-1:0]                   rd_addr;
   logic signed [cqs_pkg::WORD_W-1:0]  rd_data;

   cqs_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign kind     = cqs_pkg::req_kind_type'(req_type);
   assign is_empty = (occ_ff == '0);
   assign is_full  = (occ_ff == CNT_FULL);
   assign hit      = (rd_data == key_ff);
   assign cnt_last = (cnt_ff == CNT_ONE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cqs_pkg::FSM_IDLE: begin
            if (req_fire && !is_empty) begin
               unique case (kind)
                  cqs_pkg::REQ_ENQ:    state_in = cqs_pkg::FSM_IDLE;
                  cqs_pkg::REQ_DEQ:    state_in = cqs_pkg::FSM_DEQ;
                  cqs_pkg::REQ_SEARCH: state_in = cqs_pkg::FSM_SCAN;
                  cqs_pkg::REQ_DUMP:   state_in = cqs_pkg::FSM_DUMP;
               endcase
            end
         end
         cqs_pkg::FSM_DEQ: begin
            state_in = cqs_pkg::FSM_IDLE;
         end
         cqs_pkg::FSM_SCAN: begin
            if (hit || cnt_last) begin
               state_in = cqs_pkg::FSM_IDLE;
            end
         end
         cqs_pkg::FSM_DUMP: begin
            if (out_free && cnt_last) begin
               state_in = cqs_pkg::FSM_IDLE;
            end
         end
      endcase
   end

   // datapath control
   always_comb begin
      req_ready     = 1'b0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b1;
      rd_addr       = idx_ff;
      rsp_load      = 1'b0;
      rsp_status_in = cqs_pkg::ST_OK;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         cqs_pkg::FSM_IDLE: begin
            req_ready = out_free;
            rd_addr   = head_ff;
            if (req_fire) begin
               if (kind == cqs_pkg::REQ_ENQ) begin
                  rsp_load = 1'b1;
                  if (is_full) begin
                     rsp_status_in = cqs_pkg::ST_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     tail_in = wrap_inc(tail_ff);
                     occ_in  = occ_ff + CNT_ONE;
                  end
               end else if (is_empty) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = cqs_pkg::ST_EMPTY;
               end else begin
                  // head slot is fetched now; walk continues from the next one
                  idx_in = wrap_inc(head_ff);
                  cnt_in = occ_ff;
                  key_in = req_value;
                  if (kind == cqs_pkg::REQ_DEQ) begin
                     head_in = wrap_inc(head_ff);
                     occ_in  = occ_ff - CNT_ONE;
                  end
               end
            end
         end
         cqs_pkg::FSM_DEQ: begin
            rsp_load    = 1'b1;
            rsp_data_in = rd_data;
         end
         cqs_pkg::FSM_SCAN: begin
            if (hit) begin
               rsp_load      = 1'b1;
               rsp_status_in = cqs_pkg::ST_FOUND;
            end else if (cnt_last) begin
               rsp_load      = 1'b1;
               rsp_status_in = cqs_pkg::ST_NOTFOUND;
            end else begin
               idx_in = wrap_inc(idx_ff);
               cnt_in = cnt_ff - CNT_ONE;
            end
         end
         cqs_pkg::FSM_DUMP: begin
            // read data register holds while the output beat is stalled
            rd_en = out_free;
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = rd_data;
               rsp_last_in = cnt_last;
               idx_in      = wrap_inc(idx_ff);
               cnt_in      = cnt_ff - CNT_ONE;
            end
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cqs_pkg::FSM_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = cqs_pkg::STATUS_W'(rsp_status_ff);
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ----- hw/rtl/cqs_checker.sv -----
// Port-level checks for the circular queue, bound to the top level.
module cqs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [cqs_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [cqs_pkg::WORD_W-1:0] rsp_data,
   input logic                              rsp_last
);

   logic busy_ff;
   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // a request is open from its accept until its last beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_fire) begin
         busy_ff <= 1'b1;
      end else if (rsp_fire && rsp_last) begin
         busy_ff <= 1'b0;
      end
   end

   a_one_open: assert property (@(posedge clock) disable iff (reset)
      req_fire && busy_ff |-> rsp_fire && rsp_last)
      else $error("request accepted while another is still open");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff)
      else $error("response beat without an open request");

   a_status_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != cqs_pkg::STATUS_W'(cqs_pkg::ST_OK))
      |-> (rsp_data == '0) && rsp_last)
      else $error("non-ok status must be a single zero-data beat");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= cqs_pkg::STATUS_W'(cqs_pkg::ST_NOTFOUND)))
      else $error("status code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_data) && $stable(rsp_last))
      else $error("stalled response beat changed");

endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_data   (rsp_data),
   .rsp_last   (rsp_last)
);

// ----- tb/sv/circular_queue_with_search_tb.sv -----
// Self-checking testbench for the circular queue with search: directed corners, random traffic, scoreboard.
module circular_queue_with_search_tb;

   localparam int Q_DEPTH   = 16;
   localparam int NUM_ITEMS = 320;

   typedef struct {
      cqs_pkg::req_kind_type             kind;
      logic signed [cqs_pkg::WORD_W-1:0] value;
      bit                                drain;  // hold until every pending beat has come back
      int unsigned                       phase;
   } queue_req_type;

   typedef struct {
      cqs_pkg::status_type               status;
      logic signed [cqs_pkg::WORD_W-1:0] data;
      logic                              last;
   } rsp_beat_type;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [cqs_pkg::KIND_W-1:0]         req_type  = cqs_pkg::REQ_ENQ;
   logic signed [cqs_pkg::WORD_W-1:0]  req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [cqs_pkg::STATUS_W-1:0]       rsp_status;
   logic signed [cqs_pkg::WORD_W-1:0]  rsp_data;
   logic                               rsp_last;

   queue_req_type pending_reqs[$];
   rsp_beat_type  expected_beats[$];
   queue_req_type next_req;
   bit            req_beat = 1'b0;
   bit            mismatch_seen = 1'b0;
   int unsigned   cur_phase = 0;
   int unsigned   send_idle_pct[4] = '{0, 67, 0, 17};
   int unsigned   rsp_stall_pct[4] = '{0, 0, 67, 17};

   // predictor copy of the ring
   logic signed [cqs_pkg::WORD_W-1:0] ring_words[Q_DEPTH];
   logic [3:0]                        ring_head = '0;
   logic [3:0]                        ring_tail = '0;
   int unsigned                       ring_count = 0;

   // stimulus-side shadow, only used to steer generation
   logic signed [cqs_pkg::WORD_W-1:0] gen_words[$];

   circular_queue_with_search #(.DEPTH(Q_DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_type),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_beat_type make_beat(cqs_pkg::status_type st,
                                              logic signed [cqs_pkg::WORD_W-1:0] d,
                                              logic lst);
      rsp_beat_type b;
      b.status = st;
      b.data   = d;
      b.last   = lst;
      return b;
   endfunction

   function automatic void predict_queue_op(cqs_pkg::req_kind_type kind,
                                            logic signed [cqs_pkg::WORD_W-1:0] v);
      logic [3:0] idx;
      bit         hit;
      idx = ring_head;
      hit = 1'b0;
      if (kind == cqs_pkg::REQ_ENQ) begin
         if (ring_count == Q_DEPTH) begin
            expected_beats.push_back(make_beat(cqs_pkg::ST_FULL, '0, 1'b1));
         end else begin
            ring_words[ring_tail] = v;
            ring_tail  = ring_tail + 4'd1;
            ring_count = ring_count + 1;
            expected_beats.push_back(make_beat(cqs_pkg::ST_OK, '0, 1'b1));
         end
      end else if (ring_count == 0) begin
         expected_beats.push_back(make_beat(cqs_pkg::ST_EMPTY, '0, 1'b1));
      end else if (kind == cqs_pkg::REQ_DEQ) begin
         expected_beats.push_back(make_beat(cqs_pkg::ST_OK, ring_words[ring_head], 1'b1));
         ring_head  = ring_head + 4'd1;
         ring_count = ring_count - 1;
      end else if (kind == cqs_pkg::REQ_SEARCH) begin
         for (int n = 0; n < ring_count; n++) begin
            if (ring_words[idx] == v) hit = 1'b1;
            idx = idx + 4'd1;
         end
         if (hit) begin
            expected_beats.push_back(make_beat(cqs_pkg::ST_FOUND, '0, 1'b1));
         end else begin
            expected_beats.push_back(make_beat(cqs_pkg::ST_NOTFOUND, '0, 1'b1));
         end
      end else begin
         for (int n = 0; n < ring_count; n++) begin
            expected_beats.push_back(make_beat(cqs_pkg::ST_OK, ring_words[idx],
                                               n == ring_count - 1));
            idx = idx + 4'd1;
         end
      end
   endfunction

   function automatic logic signed [cqs_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -32'sd1;
         4: return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [cqs_pkg::WORD_W-1:0] pick_key();
      if (gen_words.size() != 0 && $urandom_range(1))
         return gen_words[$urandom_range(gen_words.size() - 1)];
      return pick_word();
   endfunction

   function automatic void add_req(cqs_pkg::req_kind_type kind,
                                   logic signed [cqs_pkg::WORD_W-1:0] v);
      queue_req_type r;
      int unsigned   k;
      k       = pending_reqs.size();
      r.kind  = kind;
      r.value = v;
      r.phase = (k / 40) % 4;
      r.drain = (k != 0) && (k % 80 == 0);
      pending_reqs.push_back(r);
      if (kind == cqs_pkg::REQ_ENQ && gen_words.size() < Q_DEPTH) gen_words.push_back(v);
      if (kind == cqs_pkg::REQ_DEQ && gen_words.size() != 0) void'(gen_words.pop_front());
   endfunction

   // stimulus and end of run
   initial begin
      int unsigned n_fill;
      int unsigned n_drain;
      // empty queue corners
      add_req(cqs_pkg::REQ_DUMP, '0);
      add_req(cqs_pkg::REQ_DEQ, '0);
      add_req(cqs_pkg::REQ_SEARCH, 32'sh7fff_ffff);
      add_req(cqs_pkg::REQ_SEARCH, 32'sh8000_0000);
      // field extremes
      add_req(cqs_pkg::REQ_ENQ, 32'sh7fff_ffff);
      add_req(cqs_pkg::REQ_ENQ, 32'sh8000_0000);
      add_req(cqs_pkg::REQ_ENQ, -32'sd1);
      add_req(cqs_pkg::REQ_ENQ, '0);
      add_req(cqs_pkg::REQ_SEARCH, '0);
      add_req(cqs_pkg::REQ_SEARCH, 32'sh7fff_ffff);
      add_req(cqs_pkg::REQ_SEARCH, 32'sh5555_aaaa);
      add_req(cqs_pkg::REQ_DUMP, 32'shffff_ffff);
      add_req(cqs_pkg::REQ_DEQ, 32'sh1234_5678);
      add_req(cqs_pkg::REQ_SEARCH, 32'sh7fff_ffff);
      add_req(cqs_pkg::REQ_DEQ, '0);
      add_req(cqs_pkg::REQ_DUMP, '0);
      add_req(cqs_pkg::REQ_DEQ, '0);
      add_req(cqs_pkg::REQ_DEQ, '0);
      add_req(cqs_pkg::REQ_DEQ, '0);
      // random part: fill and drain bursts around a mix of single ops
      while (pending_reqs.size() < NUM_ITEMS) begin
         case ($urandom_range(9))
            0, 1: begin
               n_fill = Q_DEPTH - gen_words.size() + $urandom_range(2);
               repeat (n_fill) add_req(cqs_pkg::REQ_ENQ, pick_word());
               if (gen_words.size() != 0) add_req(cqs_pkg::REQ_SEARCH, gen_words[$]);
               add_req(cqs_pkg::REQ_SEARCH, pick_key());
               add_req(cqs_pkg::REQ_DUMP, pick_word());
            end
            2: begin
               n_drain = gen_words.size() + $urandom_range(1);
               if ($urandom_range(1)) add_req(cqs_pkg::REQ_DUMP, pick_word());
               repeat (n_drain) add_req(cqs_pkg::REQ_DEQ, pick_word());
            end
            default: begin
               case ($urandom_range(9))
                  0, 1, 2, 3: add_req(cqs_pkg::REQ_ENQ, pick_word());
                  4, 5:       add_req(cqs_pkg::REQ_DEQ, pick_word());
                  6, 7, 8:    add_req(cqs_pkg::REQ_SEARCH, pick_key());
                  default:    add_req(cqs_pkg::REQ_DUMP, pick_word());
               endcase
            end
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (!mismatch_seen) begin
         $display("PASS circular_queue_with_search");
      end else begin
         $display("FAIL circular_queue_with_search");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL circular_queue_with_search");
      $finish;
   end

   // driver: request channel and response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         if (pending_reqs.size() != 0
             && !(pending_reqs[0].drain && expected_beats.size() != 0)
             && $urandom_range(99) >= send_idle_pct[pending_reqs[0].phase]) begin
            next_req  = pending_reqs.pop_front();
            cur_phase = next_req.phase;
            req_valid <= 1'b1;
            req_type  <= next_req.kind;
            req_value <= next_req.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct[cur_phase]);
   end

   // monitor: check returned beats, then predict newly accepted requests
   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      req_beat <= !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: status %0d data %0d last %0d",
                   rsp_status, rsp_data, rsp_last);
            mismatch_seen = 1'b1;
         end else begin
            exp_beat = expected_beats.pop_front();
            if (rsp_status !== exp_beat.status) begin
               $error("status: expected %0d, got %0d", exp_beat.status, rsp_status);
               mismatch_seen = 1'b1;
            end
            if (rsp_data !== exp_beat.data) begin
               $error("data: expected %0d, got %0d", exp_beat.data, rsp_data);
               mismatch_seen = 1'b1;
            end
            if (rsp_last !== exp_beat.last) begin
               $error("last: expected %0d, got %0d", exp_beat.last, rsp_last);
               mismatch_seen = 1'b1;
            end
         end
      end
      if (!reset && req_valid && req_ready)
         predict_queue_op(cqs_pkg::req_kind_type'(req_type), req_value);
   end

endmodule
